// ----- design/sbnf_pkg.sv -----
// sbnf_pkg: shared types and constants of the small-block next-fit allocator
// beat payloads, status codes and the controller/datapath command and status structs
// no dependencies
`default_nettype none

package sbnf_pkg;

    // result status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_NOFIT = 2'd1;
    localparam logic [1:0] ST_BAD   = 2'd2;

    // request modes
    localparam logic MODE_ALLOC = 1'b0;
    localparam logic MODE_FREE  = 1'b1;

    // largest allocate request in bytes
    localparam logic [15:0] MAX_REQ_BYTES = 16'd56;

    // table byte codes
    localparam logic [3:0] HDR_MARK  = 4'hF;
    localparam logic [7:0] FILL_BYTE = 8'hFF;

    typedef struct packed {
        logic        mode;
        logic [15:0] request_bytes;
        logic [8:0]  block_index;
    } sbnf_in_t;

    typedef struct packed {
        logic [1:0] status;
        logic [8:0] granted_index;
        logic [9:0] blocks_free;
        logic [8:0] live_allocations;
    } sbnf_out_t;

    // controller to datapath
    typedef struct packed {
        logic       init;
        logic       clr_step;
        logic       load_req;
        logic       scan_start;
        logic       scan_wrap;
        logic       hdr_rd;
        logic       hdr_skip;
        logic       run_begin;
        logic       run_rd;
        logic       run_adv;
        logic       run_stop;
        logic       grant;
        logic       fill;
        logic       free_rd;
        logic       free_ok;
        logic       free_clr;
        logic       res_set;
        logic [1:0] res_code;
        logic       out_load;
    } sbnf_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic clr_last;
        logic mode;
        logic alloc_bad;
        logic end_zero;
        logic start_zero;
        logic cur_at_end;
        logic rd_nonzero;
        logic skip_hits_start;
        logic it_at_goal;
        logic it_at_start;
        logic it_at_end;
        logic fill_done;
        logic free_bad_idx;
        logic free_bad_hdr;
        logic free_clr_done;
    } sbnf_sts_t;

endpackage

`default_nettype wire

// ----- design/sbnf_dp.sv -----
// sbnf_dp: datapath of the small-block next-fit allocator
// pair table memory, scan pointers, counters and the output register
// depends on sbnf_pkg
`default_nettype none

module sbnf_dp #(
    parameter int TABLE_DEPTH = 256
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire sbnf_pkg::sbnf_in_t  in_data,
    input  wire logic [9:0]          cfg_data,
    input  wire sbnf_pkg::sbnf_cmd_t cmd,
    output sbnf_pkg::sbnf_sts_t      sts,
    output sbnf_pkg::sbnf_out_t      out_data
);

    localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int EW = $clog2(TABLE_DEPTH + 8);
    localparam int CW = (EW > 9) ? EW + 1 : 10;
    localparam int END_RST  = (TABLE_DEPTH < 256) ? TABLE_DEPTH : 256;
    localparam int FREE_RST = (2 * TABLE_DEPTH < 512) ? 2 * TABLE_DEPTH : 512;

    logic [7:0]          mem [TABLE_DEPTH];
    logic [7:0]          rd_data_reg;
    logic [IW-1:0]       clr_cnt_reg;
    logic [EW-1:0]       end_reg;
    logic [EW-1:0]       cursor_reg;
    logic [EW-1:0]       cur_reg;
    logic [EW-1:0]       it_reg;
    logic [EW-1:0]       start_reg;
    logic [2:0]          k_reg;
    logic [2:0]          free_pairs_reg;
    sbnf_pkg::sbnf_in_t  req_reg;
    logic [9:0]          free_cnt_reg;
    logic [8:0]          alloc_cnt_reg;
    logic [1:0]          res_code_reg;
    logic [8:0]          res_granted_reg;
    sbnf_pkg::sbnf_out_t out_reg;

    logic [2:0]    pairs;
    logic [9:0]    len_blocks;
    logic [EW-1:0] goal;
    logic [2:0]    skip;
    logic [EW-1:0] nxt_raw;
    logic [EW-1:0] nxt_lim;
    logic [EW-1:0] nxt;
    logic [EW-1:0] fill_addr;
    logic [CW-1:0] e_c;
    logic [CW-1:0] end_c;
    logic [CW-1:0] ek_c;
    logic [CW-1:0] cur_c;
    logic [CW-1:0] granted_c;
    logic [EW-1:0] end_next;
    logic [9:0]    free_init;
    logic          mem_we;
    logic          mem_re;
    logic [IW-1:0] mem_addr;
    logic [7:0]    mem_wd;

    // pairs per allocation: ceil(bytes / 8), at least one
    always_comb
    begin
        if (req_reg.request_bytes == 16'd0)
            pairs = 3'd1;
        else
            pairs = 3'((7'(req_reg.request_bytes[5:0]) + 7'd7) >> 3);
    end

    assign len_blocks = {6'd0, pairs, 1'b0};
    assign goal       = cur_reg + EW'(pairs);

    // skip over a used entry by half its length, clipped to table end and scan start
    assign skip    = (rd_data_reg[7:5] == 3'd0) ? 3'd1 : rd_data_reg[7:5];
    assign nxt_raw = cur_reg + EW'(skip);
    assign nxt_lim = (nxt_raw > end_reg) ? end_reg : nxt_raw;
    assign nxt     = ((cur_reg < start_reg) && (nxt_lim > start_reg)) ? start_reg : nxt_lim;

    assign fill_addr = cur_reg + EW'(k_reg);
    assign e_c       = {{(CW-8){1'b0}}, req_reg.block_index[8:1]};
    assign end_c     = {{(CW-EW){1'b0}}, end_reg};
    assign ek_c      = e_c + CW'(k_reg);
    assign cur_c     = {{(CW-EW){1'b0}}, cur_reg};
    assign granted_c = {cur_c[CW-2:0], 1'b0};

    assign end_next  = (int'(cfg_data[9:1]) > TABLE_DEPTH) ? EW'(TABLE_DEPTH)
                                                           : EW'(cfg_data[9:1]);
    assign free_init = (int'(cfg_data) > 2 * TABLE_DEPTH) ? 10'(2 * TABLE_DEPTH) : cfg_data;

    always_comb
    begin
        sts.clr_last        = (clr_cnt_reg == IW'(TABLE_DEPTH - 1));
        sts.mode            = req_reg.mode;
        sts.alloc_bad       = (req_reg.request_bytes > sbnf_pkg::MAX_REQ_BYTES);
        sts.end_zero        = (end_reg == '0);
        sts.start_zero      = (start_reg == '0);
        sts.cur_at_end      = (cur_reg == end_reg);
        sts.rd_nonzero      = (rd_data_reg != 8'd0);
        sts.skip_hits_start = (nxt == start_reg);
        sts.it_at_goal      = (it_reg == goal);
        sts.it_at_start     = (it_reg == start_reg);
        sts.it_at_end       = (it_reg == end_reg);
        sts.fill_done       = (k_reg == pairs);
        sts.free_bad_idx    = req_reg.block_index[0] || (e_c >= end_c);
        sts.free_bad_hdr    = (rd_data_reg[3:0] != sbnf_pkg::HDR_MARK) || rd_data_reg[4]
                              || (rd_data_reg[7:5] == 3'd0);
        sts.free_clr_done   = (k_reg == free_pairs_reg) || (ek_c == end_c);
    end

    // single port of the pair table
    always_comb
    begin
        mem_we   = 1'b0;
        mem_re   = 1'b0;
        mem_addr = '0;
        mem_wd   = 8'd0;
        if (cmd.clr_step)
        begin
            mem_we   = 1'b1;
            mem_addr = clr_cnt_reg;
        end
        else if (cmd.hdr_rd)
        begin
            mem_re   = 1'b1;
            mem_addr = cur_reg[IW-1:0];
        end
        else if (cmd.run_rd)
        begin
            mem_re   = 1'b1;
            mem_addr = it_reg[IW-1:0];
        end
        else if (cmd.free_rd)
        begin
            mem_re   = 1'b1;
            mem_addr = e_c[IW-1:0];
        end
        else if (cmd.grant)
        begin
            mem_we   = 1'b1;
            mem_addr = cur_reg[IW-1:0];
            mem_wd   = {pairs, 1'b0, sbnf_pkg::HDR_MARK};
        end
        else if (cmd.fill)
        begin
            mem_we   = 1'b1;
            mem_addr = fill_addr[IW-1:0];
            mem_wd   = sbnf_pkg::FILL_BYTE;
        end
        else if (cmd.free_clr)
        begin
            mem_we   = 1'b1;
            mem_addr = ek_c[IW-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_addr] <= mem_wd;
        if (mem_re)
            rd_data_reg <= mem[mem_addr];
    end

    // control state: sizes, cursor, counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg   <= '0;
            end_reg       <= EW'(END_RST);
            cursor_reg    <= '0;
            free_cnt_reg  <= 10'(FREE_RST);
            alloc_cnt_reg <= 9'd0;
        end
        else if (cmd.init)
        begin
            clr_cnt_reg   <= '0;
            end_reg       <= end_next;
            cursor_reg    <= '0;
            free_cnt_reg  <= free_init;
            alloc_cnt_reg <= 9'd0;
        end
        else
        begin
            if (cmd.clr_step)
                clr_cnt_reg <= clr_cnt_reg + IW'(1);
            if (cmd.scan_start && (cursor_reg >= end_reg))
                cursor_reg <= '0;
            if (cmd.grant)
            begin
                cursor_reg    <= (goal == end_reg) ? '0 : cur_reg;
                free_cnt_reg  <= (free_cnt_reg >= len_blocks) ? free_cnt_reg - len_blocks
                                                              : 10'd0;
                alloc_cnt_reg <= alloc_cnt_reg + 9'd1;
            end
            if (cmd.free_ok)
            begin
                free_cnt_reg <= free_cnt_reg + {6'd0, rd_data_reg[7:4]};
                if (alloc_cnt_reg != 9'd0)
                    alloc_cnt_reg <= alloc_cnt_reg - 9'd1;
            end
        end
    end

    // payload: request, scan pointers, result
    always_ff @(posedge clk)
    begin
        if (cmd.load_req)
            req_reg <= in_data;
        if (cmd.scan_start)
        begin
            cur_reg   <= (cursor_reg >= end_reg) ? '0 : cursor_reg;
            start_reg <= (cursor_reg >= end_reg) ? '0 : cursor_reg;
        end
        if (cmd.scan_wrap)
            cur_reg <= '0;
        if (cmd.hdr_skip)
            cur_reg <= nxt;
        if (cmd.run_begin)
            it_reg <= cur_reg + EW'(1);
        if (cmd.run_adv)
            it_reg <= it_reg + EW'(1);
        if (cmd.run_stop)
            cur_reg <= it_reg;
        if (cmd.grant)
        begin
            k_reg           <= 3'd1;
            res_code_reg    <= sbnf_pkg::ST_OK;
            res_granted_reg <= granted_c[8:0];
        end
        if (cmd.fill || cmd.free_clr)
            k_reg <= k_reg + 3'd1;
        if (cmd.free_ok)
        begin
            k_reg           <= 3'd0;
            free_pairs_reg  <= rd_data_reg[7:5];
            res_code_reg    <= sbnf_pkg::ST_OK;
            res_granted_reg <= 9'd0;
        end
        if (cmd.res_set)
        begin
            res_code_reg    <= cmd.res_code;
            res_granted_reg <= 9'd0;
        end
        if (cmd.out_load)
        begin
            out_reg.status           <= res_code_reg;
            out_reg.granted_index    <= res_granted_reg;
            out_reg.blocks_free      <= free_cnt_reg;
            out_reg.live_allocations <= alloc_cnt_reg;
        end
    end

    assign out_data = out_reg;

`ifndef SYNTH
    a_port_single: assert property (@(posedge clk) disable iff (!rst_n)
        !(mem_we && mem_re))
        else $error("pair table read and write in the same cycle");

    a_hdr_in_table: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.hdr_rd |-> (cur_reg < end_reg))
        else $error("header read beyond table end");

    a_run_in_table: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.run_rd |-> (it_reg < end_reg))
        else $error("run probe beyond table end");

    a_grant_fits: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.grant |-> (goal <= end_reg))
        else $error("granted run extends past table end");
`endif

endmodule

`default_nettype wire

// ----- design/sbnf_ctrl.sv -----
// sbnf_ctrl: controller state machine of the small-block next-fit allocator
// sequences table clearing, the next-fit scan, run writes and frees
// depends on sbnf_pkg
`default_nettype none

module sbnf_ctrl (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    output logic                     out_valid,
    input  wire logic                out_ready,
    input  wire logic                cfg_we,
    input  wire sbnf_pkg::sbnf_sts_t sts,
    output sbnf_pkg::sbnf_cmd_t      cmd
);

    localparam logic [3:0] S_CLEAR    = 4'd0;
    localparam logic [3:0] S_IDLE     = 4'd1;
    localparam logic [3:0] S_DECODE   = 4'd2;
    localparam logic [3:0] S_SCAN     = 4'd3;
    localparam logic [3:0] S_HDR      = 4'd4;
    localparam logic [3:0] S_RUN      = 4'd5;
    localparam logic [3:0] S_RUNCHK   = 4'd6;
    localparam logic [3:0] S_FILL     = 4'd7;
    localparam logic [3:0] S_FREE_HDR = 4'd8;
    localparam logic [3:0] S_FREE_CLR = 4'd9;
    localparam logic [3:0] S_FINISH   = 4'd10;

    logic [3:0] state_reg;
    logic [3:0] state_next;
    logic       out_valid_reg;
    logic       out_valid_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.clr_step = 1'b1;
                if (cfg_we)
                    cmd.init = 1'b1;
                else if (sts.clr_last)
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (cfg_we)
                begin
                    cmd.init   = 1'b1;
                    state_next = S_CLEAR;
                end
                else if (in_valid)
                begin
                    cmd.load_req = 1'b1;
                    state_next   = S_DECODE;
                end
            end
            S_DECODE:
            begin
                if (sts.mode == sbnf_pkg::MODE_ALLOC)
                begin
                    if (sts.alloc_bad)
                    begin
                        cmd.res_set  = 1'b1;
                        cmd.res_code = sbnf_pkg::ST_BAD;
                        state_next   = S_FINISH;
                    end
                    else if (sts.end_zero)
                    begin
                        cmd.res_set  = 1'b1;
                        cmd.res_code = sbnf_pkg::ST_NOFIT;
                        state_next   = S_FINISH;
                    end
                    else
                    begin
                        cmd.scan_start = 1'b1;
                        state_next     = S_SCAN;
                    end
                end
                else if (sts.free_bad_idx)
                begin
                    cmd.res_set  = 1'b1;
                    cmd.res_code = sbnf_pkg::ST_BAD;
                    state_next   = S_FINISH;
                end
                else
                begin
                    cmd.free_rd = 1'b1;
                    state_next  = S_FREE_HDR;
                end
            end
            S_SCAN:
            begin
                if (sts.cur_at_end)
                begin
                    if (sts.start_zero)
                    begin
                        cmd.res_set  = 1'b1;
                        cmd.res_code = sbnf_pkg::ST_NOFIT;
                        state_next   = S_FINISH;
                    end
                    else
                        cmd.scan_wrap = 1'b1;
                end
                else
                begin
                    cmd.hdr_rd = 1'b1;
                    state_next = S_HDR;
                end
            end
            S_HDR:
            begin
                if (sts.rd_nonzero)
                begin
                    cmd.hdr_skip = 1'b1;
                    if (sts.skip_hits_start)
                    begin
                        cmd.res_set  = 1'b1;
                        cmd.res_code = sbnf_pkg::ST_NOFIT;
                        state_next   = S_FINISH;
                    end
                    else
                        state_next = S_SCAN;
                end
                else
                begin
                    cmd.run_begin = 1'b1;
                    state_next    = S_RUN;
                end
            end
            S_RUN:
            begin
                if (sts.it_at_goal)
                begin
                    cmd.grant  = 1'b1;
                    state_next = S_FILL;
                end
                else if (sts.it_at_start)
                begin
                    cmd.res_set  = 1'b1;
                    cmd.res_code = sbnf_pkg::ST_NOFIT;
                    state_next   = S_FINISH;
                end
                else if (sts.it_at_end)
                begin
                    cmd.scan_wrap = 1'b1;
                    if (sts.start_zero)
                    begin
                        cmd.res_set  = 1'b1;
                        cmd.res_code = sbnf_pkg::ST_NOFIT;
                        state_next   = S_FINISH;
                    end
                    else
                        state_next = S_SCAN;
                end
                else
                begin
                    cmd.run_rd = 1'b1;
                    state_next = S_RUNCHK;
                end
            end
            S_RUNCHK:
            begin
                if (sts.rd_nonzero)
                begin
                    cmd.run_stop = 1'b1;
                    state_next   = S_SCAN;
                end
                else
                begin
                    cmd.run_adv = 1'b1;
                    state_next  = S_RUN;
                end
            end
            S_FILL:
            begin
                if (sts.fill_done)
                    state_next = S_FINISH;
                else
                    cmd.fill = 1'b1;
            end
            S_FREE_HDR:
            begin
                if (sts.free_bad_hdr)
                begin
                    cmd.res_set  = 1'b1;
                    cmd.res_code = sbnf_pkg::ST_BAD;
                    state_next   = S_FINISH;
                end
                else
                begin
                    cmd.free_ok = 1'b1;
                    state_next  = S_FREE_CLR;
                end
            end
            S_FREE_CLR:
            begin
                if (sts.free_clr_done)
                    state_next = S_FINISH;
                else
                    cmd.free_clr = 1'b1;
            end
            S_FINISH:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.out_load)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == S_IDLE) && !cfg_we;
    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

// ----- design/small_block_next_fit_allocator_top.sv -----
// small_block_next_fit_allocator_top: top level of the small-block next-fit allocator
// joins the controller and the datapath
// depends on sbnf_pkg, sbnf_ctrl, sbnf_dp
//
// usage
//   input channel (in_valid/in_ready/in_data): one beat is one allocate or free request
//   output channel (out_valid/out_ready/out_data): one result beat per request, in order
//   cfg_we/cfg_data: pool size in blocks, written with no wait while the block is idle
// sequence of a request
//   allocate: the scan reads each visited table entry through the registered
//     one-port pair table read, steps over a used run as one entry, then writes
//     the header and one fill byte per further pair of the granted run
//   bad allocate request or empty pool: answered from the decode state
//   free: reads the header, then clears the pairs of the run; bad free: no clear
//   one request is in flight at a time; in_ready returns once the result is handed
//   to the output register
// reset and configuration
//   after reset and after every pool size write the whole pair table is cleared
//   one entry per cycle, with in_ready low
// stall
//   a result waiting on out_ready stays in the output register; the next request is
//   still taken and worked on, and only its own handoff waits for the register
`default_nettype none

module small_block_next_fit_allocator_top #(
    parameter int TABLE_DEPTH = 256
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire sbnf_pkg::sbnf_in_t in_data,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output sbnf_pkg::sbnf_out_t     out_data,
    input  wire logic               cfg_we,
    input  wire logic [9:0]         cfg_data
);

    // command and status between sequencer and datapath
    sbnf_pkg::sbnf_cmd_t cmd;
    sbnf_pkg::sbnf_sts_t sts;

    sbnf_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cfg_we    (cfg_we),
        .sts       (sts),
        .cmd       (cmd)
    );

    // pair table, scan pointers, counters and the output register
    sbnf_dp #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_data  (in_data),
        .cfg_data (cfg_data),
        .cmd      (cmd),
        .sts      (sts),
        .out_data (out_data)
    );

endmodule

`default_nettype wire
